// ----- sv/heightmap_edge_preserving_smooth_core_macros.svh -----
// Assertion macros for the edge-preserving height smoothing core.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef HEIGHTMAP_EDGE_PRESERVING_SMOOTH_CORE_MACROS_SVH
`define HEIGHTMAP_EDGE_PRESERVING_SMOOTH_CORE_MACROS_SVH
`ifndef SYNTH
// check outside reset
`define HMEPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// check at every edge, reset included
`define HMEPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define HMEPS_ASSERT(lbl, prop, msg)
`define HMEPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/hmeps_pkg.sv -----
// Shared types and constants of the edge-preserving height smoothing core.
// No dependencies; every module of the core and its testbench imports it.
`timescale 1ns / 1ps
package hmeps_pkg;

  localparam int HEIGHT_W    = 20;
  localparam int ROW_WIDTH_W = 11;
  localparam int THRESH_W    = 19;
  localparam int CFG_DATA_W  = 19;
  localparam int CFG_IDX_W   = 1;

  // centre weight and weight count width (count runs 4..8)
  localparam int CENTRE_WEIGHT = 4;
  localparam int CNT_W         = 4;

  // running sum holds up to eight heights
  localparam int SUM_W   = HEIGHT_W + 4;
  // biased dividend, padded to whole 4-bit digits
  localparam int DIGIT_W    = 4;
  localparam int DIV_NUM_W  = ((SUM_W + 3 + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam int DIV_STEPS  = DIV_NUM_W / DIGIT_W;

  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int CMP_W  = (DIFF_W > THRESH_W) ? DIFF_W : THRESH_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 1'd1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd256;
  localparam logic [THRESH_W-1:0]    THRESH_RST    = 19'd800;

  typedef logic signed [HEIGHT_W-1:0] height_t;

  typedef struct packed {
    logic    func;
    height_t height_in;
  } hmeps_in_t;

  typedef struct packed {
    height_t smoothed_height;
    logic    frame_last;
  } hmeps_out_t;

  typedef enum logic [1:0] {
    NB_UP,
    NB_LEFT,
    NB_RIGHT,
    NB_DOWN
  } nb_sel_e;

  typedef struct packed {
    logic    load;
    logic    clear;
    logic    rd_left;
    logic    cap_main;
    logic    cap_left;
    logic    advance;
    logic    init_acc;
    logic    acc;
    nb_sel_e nb_sel;
    logic    div_start;
    logic    out_load;
  } hmeps_cmd_t;

  typedef struct packed {
    logic       func;
    logic [1:0] rows_seen;
    logic       col_nz;
    logic       drain_nz;
    logic       div_busy;
    logic       div_done;
    logic       out_busy;
  } hmeps_sts_t;

endpackage

// ----- sv/hmeps_div.sv -----
// Floor division of the neighbour sum by the weight count, rounding to nearest.
// Restoring divider, four quotient bits per cycle. Depends on hmeps_pkg.
`timescale 1ns / 1ps
module hmeps_div import hmeps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SUM_W-1:0]    sum_i,
  input  logic [CNT_W-1:0]    cnt_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [HEIGHT_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(DIV_STEPS + 1);
  localparam int REM_W  = CNT_W - 1;

  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIGIT_W-1:0]   digit_n;
  logic [STEP_W-1:0]    step_q;
  logic                 busy_q, done_q;

  // sum + floor(cnt/2) + cnt * 2^(SUM_W-1): nonnegative, and the bias
  // only touches quotient bits above the height
  assign num_d = {{(DIV_NUM_W-SUM_W){sum_i[SUM_W-1]}}, sum_i}
               + DIV_NUM_W'(cnt_i >> 1)
               + (DIV_NUM_W'(cnt_i) << (SUM_W - 1));

  always_comb begin
    logic [REM_W-1:0] r;
    logic [CNT_W-1:0] r4;
    r       = rem_q;
    digit_n = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      r4 = {r, num_q[DIV_NUM_W - DIGIT_W + i]};
      if (r4 >= cnt_q) begin
        digit_n[i] = 1'b1;
        r4         = r4 - cnt_q;
      end
      r = r4[REM_W-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= STEP_W'(DIV_STEPS);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend bits shift out on top, quotient digits shift in below
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_d;
      cnt_q <= cnt_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NUM_W-DIGIT_W-1:0], digit_n};
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q[HEIGHT_W-1:0];

endmodule

// ----- sv/hmeps_dpath.sv -----
// Datapath: line stores, row counters, neighbour accumulator, output register.
// Depends on hmeps_pkg and hmeps_div; driven by hmeps_ctrl commands.
`timescale 1ns / 1ps
module hmeps_dpath import hmeps_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hmeps_cmd_t             cmd_i,
  output hmeps_sts_t             sts_o,
  input  hmeps_in_t              in_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hmeps_out_t             out_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int EWW = (CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W;

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [THRESH_W-1:0]    thr_q;

  logic [AW-1:0] col_q, drain_q;
  logic [1:0]    rows_q;

  logic [HEIGHT_W-1:0] upper_mem  [MAX_WIDTH];
  logic [HEIGHT_W-1:0] centre_mem [MAX_WIDTH];
  logic [HEIGHT_W-1:0] ca_rd_q, cb_rd_q, ua_rd_q, ub_rd_q;

  logic                func_q, last_q;
  logic [HEIGHT_W-1:0] h_q, ctr_q;
  logic [AW-1:0]       a_q, a_in, a_p1, a_m1, cb_addr;
  logic [3:0]          en_q;
  logic [HEIGHT_W-1:0] nb_q [4];

  logic [EWW-1:0] row_w_x, w_eff, a_next_x;
  logic           last_in;

  logic [SUM_W-1:0]    sum_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [HEIGHT_W-1:0] nb;
  logic [DIFF_W-1:0]   diff, absd;
  logic                take;

  logic                out_valid_q;
  hmeps_out_t          out_q;
  logic                div_busy, div_done;
  logic [HEIGHT_W-1:0] quot;

  // width register: zero acts as one, too wide acts as the store depth
  assign row_w_x = EWW'(row_width_q);
  always_comb begin
    priority if (row_w_x == '0) begin
      w_eff = EWW'(1);
    end else if (row_w_x > EWW'(MAX_WIDTH)) begin
      w_eff = EWW'(MAX_WIDTH);
    end else begin
      w_eff = row_w_x;
    end
  end

  assign a_in     = in_i.func ? drain_q : col_q;
  assign a_next_x = EWW'(a_in) + EWW'(1);
  assign last_in  = (a_next_x >= w_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      thr_q       <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_WIDTH:      row_width_q <= cfg_wdata_i[ROW_WIDTH_W-1:0];
        REG_EDGE_THRESHOLD: thr_q       <= cfg_wdata_i[THRESH_W-1:0];
      endcase
    end
  end

  // latch the beat and its neighbour flags before the counters move
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q         <= in_i.func;
      h_q            <= in_i.height_in;
      a_q            <= a_in;
      last_q         <= last_in;
      en_q[NB_UP]    <= (rows_q == 2'd2);
      en_q[NB_LEFT]  <= (a_in != '0);
      en_q[NB_RIGHT] <= !last_in;
      en_q[NB_DOWN]  <= !in_i.func;
    end
  end

  assign a_p1    = a_q + 1'b1;
  assign a_m1    = a_q - 1'b1;
  assign cb_addr = cmd_i.rd_left ? a_m1 : a_p1;

  // line stores: one write, two registered reads each
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance && !func_q) begin
      upper_mem[a_q]  <= ctr_q;
      centre_mem[a_q] <= h_q;
    end
    ca_rd_q <= centre_mem[a_q];
    cb_rd_q <= centre_mem[cb_addr];
    ua_rd_q <= upper_mem[a_q];
    ub_rd_q <= upper_mem[a_m1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_main) begin
      ctr_q           <= ca_rd_q;
      nb_q[NB_UP]     <= ua_rd_q;
      nb_q[NB_LEFT]   <= ub_rd_q;
      nb_q[NB_RIGHT]  <= cb_rd_q;
      nb_q[NB_DOWN]   <= h_q;
    end else if (cmd_i.cap_left && func_q) begin
      // final row: left neighbour sits in the centre store
      nb_q[NB_LEFT] <= cb_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      rows_q  <= '0;
      drain_q <= '0;
    end else if (cmd_i.clear) begin
      col_q   <= '0;
      rows_q  <= '0;
      drain_q <= '0;
    end else if (cmd_i.advance) begin
      if (!func_q) begin
        if (last_q) begin
          col_q <= '0;
          if (rows_q != 2'd2) begin
            rows_q <= rows_q + 2'd1;
          end
        end else begin
          col_q <= a_p1;
        end
      end else if (last_q) begin
        col_q   <= '0;
        rows_q  <= '0;
        drain_q <= '0;
      end else begin
        drain_q <= a_p1;
      end
    end
  end

  // one neighbour per cycle: keep it if |nb - centre| < threshold
  assign nb   = nb_q[cmd_i.nb_sel];
  assign diff = {nb[HEIGHT_W-1], nb} - {ctr_q[HEIGHT_W-1], ctr_q};
  assign absd = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign take = en_q[cmd_i.nb_sel] && (CMP_W'(absd) < CMP_W'(thr_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_acc) begin
      sum_q <= {{(SUM_W-HEIGHT_W-2){ctr_q[HEIGHT_W-1]}}, ctr_q, 2'b00};
      cnt_q <= CNT_W'(CENTRE_WEIGHT);
    end else if (cmd_i.acc && take) begin
      sum_q <= sum_q + {{(SUM_W-HEIGHT_W){nb[HEIGHT_W-1]}}, nb};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  hmeps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .sum_i   (sum_q),
    .cnt_i   (cnt_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.smoothed_height <= quot;
      out_q.frame_last      <= func_q && last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sts_o.func      = func_q;
  assign sts_o.rows_seen = rows_q;
  assign sts_o.col_nz    = (col_q != '0);
  assign sts_o.drain_nz  = (drain_q != '0);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ----- sv/hmeps_ctrl.sv -----
// Controller: sequences one beat at a time through read, accumulate, divide.
// Depends on hmeps_pkg; drives hmeps_dpath through command and status structs.
`timescale 1ns / 1ps
module hmeps_ctrl import hmeps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hmeps_sts_t sts_i,
  output hmeps_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_LEFT,
    S_CAPTURE,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  state_e  state_q, state_d;
  nb_sel_e k_q, k_d;
  logic    ignore, discard, emit;

  // sample while draining: drop; drain without a full row or mid-row: discard frame
  assign ignore  = !sts_i.func && sts_i.drain_nz;
  assign discard = sts_i.func && ((sts_i.rows_seen == 2'd0) || sts_i.col_nz);
  assign emit    = sts_i.func || (sts_i.rows_seen != 2'd0);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (ignore) begin
          state_d = S_IDLE;
        end else if (discard) begin
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_RD_LEFT;
        end
      end
      S_RD_LEFT: begin
        cmd_o.rd_left  = 1'b1;
        cmd_o.cap_main = 1'b1;
        state_d        = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd_o.cap_left = 1'b1;
        cmd_o.advance  = 1'b1;
        cmd_o.init_acc = 1'b1;
        k_d            = NB_UP;
        state_d        = emit ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.nb_sel = k_q;
        if (k_q == NB_DOWN) begin
          state_d = S_DIV_GO;
        end else begin
          k_d = nb_sel_e'(k_q + 2'd1);
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= NB_UP;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

// ----- sv/heightmap_edge_preserving_smooth_core.sv -----
// Edge-preserving smoothing of a streamed height map; top of hmeps_ctrl and hmeps_dpath.
// One beat at a time: a beat that emits passes decide, the store reads and capture, the
// one-per-cycle neighbour accumulator, the 4-bit-per-cycle divider and the output load
// before the next accept; a first-row sample ends after capture, a dropped or discarded
// beat after decide. An earlier result still waiting on the output stalls the next.
// Reset clears counters and loads default width and threshold, not the line stores.
`timescale 1ns / 1ps
`include "heightmap_edge_preserving_smooth_core_macros.svh"
module heightmap_edge_preserving_smooth_core import hmeps_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hmeps_in_t             in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hmeps_out_t            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  hmeps_cmd_t cmd;
  hmeps_sts_t sts;

  hmeps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hmeps_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  `HMEPS_ASSERT(a_ready_not_dividing, in_ready_o |-> !sts.div_busy, "ready while dividing")
  `HMEPS_ASSERT(a_one_beat_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o, "second beat taken")
  `HMEPS_ASSERT(a_rows_saturate, sts.rows_seen != 2'd3, "row count past two")

endmodule

// ----- verif/tb_heightmap_edge_preserving_smooth_core.sv -----
`timescale 1ns / 1ps
// Testbench of heightmap_edge_preserving_smooth_core: directed and random height frames,
// each smoothed pixel checked against a line-buffer model of the cross stencil kept here.
// Depends on hmeps_pkg and the RTL of the core.
module tb_heightmap_edge_preserving_smooth_core;
  import hmeps_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_BEATS  = 600;
  localparam int WIDE_BEATS    = 120;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_DRAIN  = 1'b1;

  localparam height_t H_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam height_t H_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
  localparam int unsigned THRESH_MAX = (1 << THRESH_W) - 1;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  hmeps_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hmeps_out_t            out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // filter model state
  logic [ROW_WIDTH_W-1:0] m_row_width = ROW_WIDTH_RST;
  logic [THRESH_W-1:0]    m_thresh    = THRESH_RST;
  height_t                upper_line [MAX_W];
  height_t                centre_line[MAX_W];
  int unsigned            col_pos   = 0;
  int unsigned            rows_done = 0;
  int unsigned            drain_pos = 0;

  hmeps_out_t  expected_px[$];
  bit          calm         = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_fail       = 0;
  int unsigned n_beats      = 0;
  int unsigned n_checked    = 0;
  int unsigned n_frames     = 0;
  int unsigned n_strays     = 0;

  heightmap_edge_preserving_smooth_core #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned live_width();
    if (m_row_width == 0) return 1;
    if (m_row_width > MAX_W) return MAX_W;
    return m_row_width;
  endfunction

  function automatic void add_if_close(input longint ctr, input longint nb,
                                       inout longint sum, inout longint cnt);
    longint diff;
    diff = nb - ctr;
    if (diff < 0) diff = -diff;
    if (diff < longint'(m_thresh)) begin
      sum += nb;
      cnt += 1;
    end
  endfunction

  // nearest, ties toward plus infinity
  function automatic height_t rounded_mean(input longint sum, input longint cnt);
    longint num;
    longint den;
    longint q;
    num = 2 * sum + cnt;
    den = 2 * cnt;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q -= 1;
    return height_t'(q);
  endfunction

  function automatic void clear_frame_counters();
    col_pos   = 0;
    rows_done = 0;
    drain_pos = 0;
  endfunction

  function automatic bit smooth_beat(input hmeps_in_t beat, output hmeps_out_t px);
    int unsigned w;
    int unsigned c;
    int unsigned d;
    longint      sum;
    longint      cnt;
    longint      ctr;
    height_t     h;
    bit          fired;
    w     = live_width();
    h     = beat.height_in;
    px    = '0;
    fired = 1'b0;
    if (beat.func == FUNC_SAMPLE) begin
      if (drain_pos != 0) return 1'b0;
      c   = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      ctr = centre_line[c];
      if (rows_done >= 1) begin
        sum = CENTRE_WEIGHT * ctr;
        cnt = CENTRE_WEIGHT;
        add_if_close(ctr, longint'(h), sum, cnt);
        if (rows_done >= 2) add_if_close(ctr, longint'(upper_line[c]), sum, cnt);
        if (c > 0) add_if_close(ctr, longint'(upper_line[c-1]), sum, cnt);
        if (c + 1 < w) add_if_close(ctr, longint'(centre_line[c+1]), sum, cnt);
        px.smoothed_height = rounded_mean(sum, cnt);
        px.frame_last      = 1'b0;
        fired              = 1'b1;
      end
      upper_line[c]  = height_t'(ctr);
      centre_line[c] = h;
      if (c + 1 >= w) begin
        col_pos = 0;
        if (rows_done < 2) rows_done++;
      end else begin
        col_pos = c + 1;
      end
      return fired;
    end
    // drain: drop the frame unless whole rows are waiting
    if (rows_done == 0 || col_pos != 0) begin
      clear_frame_counters();
      return 1'b0;
    end
    d   = (drain_pos >= MAX_W) ? MAX_W - 1 : drain_pos;
    ctr = centre_line[d];
    sum = CENTRE_WEIGHT * ctr;
    cnt = CENTRE_WEIGHT;
    if (rows_done >= 2) add_if_close(ctr, longint'(upper_line[d]), sum, cnt);
    if (d > 0) add_if_close(ctr, longint'(centre_line[d-1]), sum, cnt);
    if (d + 1 < w) add_if_close(ctr, longint'(centre_line[d+1]), sum, cnt);
    px.smoothed_height = rounded_mean(sum, cnt);
    px.frame_last      = (d + 1 >= w);
    if (d + 1 >= w) clear_frame_counters();
    else drain_pos = d + 1;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk_i) begin
    hmeps_out_t px;
    if (in_valid && in_ready) begin
      n_beats++;
      if (smooth_beat(in_data, px)) expected_px = {expected_px, px};
    end
  end

  always @(posedge clk_i) begin
    hmeps_out_t want;
    if (out_valid && out_ready) begin
      n_checked++;
      if (out_data.frame_last) n_frames++;
      if (expected_px.size() == 0) begin
        $error("smoothed_height: no pixel expected, got %0d", out_data.smoothed_height);
        n_fail++;
      end else begin
        want = expected_px.pop_front();
        if (out_data.smoothed_height !== want.smoothed_height) begin
          $error("smoothed_height: expected %0d, got %0d",
                 want.smoothed_height, out_data.smoothed_height);
          n_fail++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, out_data.frame_last);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d pixels still expected",
               quiet_cycles, expected_px.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  task automatic push_beat(input logic op, input height_t h);
    int unsigned gap;
    bit          took;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: op, height_in: h};
    // sample ready mid-cycle, it holds until the next edge
    do begin
      @(negedge clk_i);
      took = in_ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    if (idx == REG_ROW_WIDTH) m_row_width = ROW_WIDTH_W'(value);
    else m_thresh = THRESH_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic height_t rand_height(input height_t base, input int unsigned spread,
                                          input bit wild);
    if (wild) return height_t'($urandom());
    return height_t'(longint'(base) + longint'($urandom_range(0, 2 * spread))
                     - longint'(spread));
  endfunction

  task automatic send_samples(input int unsigned n, input height_t base,
                              input int unsigned spread, input bit wild);
    for (int unsigned i = 0; i < n; i++) push_beat(FUNC_SAMPLE, rand_height(base, spread, wild));
  endtask

  task automatic send_drains(input int unsigned n, input bit strays);
    for (int unsigned i = 0; i < n; i++) begin
      // a sample between drains must be dropped
      if (strays && i > 0 && $urandom_range(0, 2) == 0) begin
        push_beat(FUNC_SAMPLE, height_t'($urandom()));
        n_strays++;
      end
      push_beat(FUNC_DRAIN, height_t'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_height_extremes();
    write_reg(REG_ROW_WIDTH, 2);
    write_reg(REG_EDGE_THRESHOLD, THRESH_MAX);
    push_beat(FUNC_SAMPLE, H_MAX);
    push_beat(FUNC_SAMPLE, H_MIN);
    push_beat(FUNC_SAMPLE, H_MIN);
    push_beat(FUNC_SAMPLE, H_MAX);
    push_beat(FUNC_SAMPLE, H_MAX);
    push_beat(FUNC_SAMPLE, H_MAX);
    send_drains(2, 1'b0);
    settle();
  endtask

  task automatic test_discarded_frames();
    write_reg(REG_ROW_WIDTH, 3);
    push_beat(FUNC_DRAIN, H_MIN);
    push_beat(FUNC_SAMPLE, 20'sd100);
    push_beat(FUNC_SAMPLE, -20'sd100);
    push_beat(FUNC_DRAIN, H_MAX);
    settle();
  endtask

  task automatic test_width_zero();
    write_reg(REG_ROW_WIDTH, 0);
    push_beat(FUNC_SAMPLE, 20'sd5);
    push_beat(FUNC_SAMPLE, -20'sd3);
    push_beat(FUNC_DRAIN, '0);
    settle();
  endtask

  task automatic test_sample_during_drain();
    write_reg(REG_ROW_WIDTH, 2);
    push_beat(FUNC_SAMPLE, 20'sd37);
    push_beat(FUNC_SAMPLE, 20'sd40);
    push_beat(FUNC_DRAIN, '0);
    push_beat(FUNC_SAMPLE, H_MIN);
    push_beat(FUNC_DRAIN, '0);
    settle();
  endtask

  task automatic test_narrow_mid_frame();
    write_reg(REG_ROW_WIDTH, 3);
    push_beat(FUNC_SAMPLE, 20'sd16);
    push_beat(FUNC_SAMPLE, 20'sd48);
    push_beat(FUNC_SAMPLE, -20'sd16);
    push_beat(FUNC_SAMPLE, 20'sd20);
    settle();
    // column 1 now lies past the new width and closes its row
    write_reg(REG_ROW_WIDTH, 1);
    push_beat(FUNC_SAMPLE, 20'sd30);
    push_beat(FUNC_SAMPLE, 20'sd25);
    push_beat(FUNC_DRAIN, '0);
    settle();
  endtask

  task automatic test_widest_rows();
    height_t base;
    base = height_t'($urandom());
    // widest register value: no row closes early, then the open frame is dropped
    write_reg(REG_ROW_WIDTH, (1 << ROW_WIDTH_W) - 1);
    write_reg(REG_EDGE_THRESHOLD, 600);
    send_samples(WIDE_BEATS, base, 500, 1'b0);
    push_beat(FUNC_DRAIN, '0);
    settle();
    write_reg(REG_ROW_WIDTH, 8);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned r;
    int unsigned w;
    int unsigned w2;
    int unsigned j;
    int unsigned spread;
    height_t     base;
    bit          wild;
    start = n_beats;
    while (n_beats - start - n_strays < RANDOM_BEATS) begin
      settle();
      calm = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 3) w = 0;
        else if (r < 10) w = 1;
        else if (r < 70) w = $urandom_range(2, 8);
        else if (r < 95) w = $urandom_range(9, 40);
        else w = $urandom_range(41, 160);
        write_reg(REG_ROW_WIDTH, w);
      end
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) write_reg(REG_EDGE_THRESHOLD, 0);
        else if (r < 20) write_reg(REG_EDGE_THRESHOLD, THRESH_MAX);
        else if (r < 30) write_reg(REG_EDGE_THRESHOLD, 1);
        else if (r < 60) write_reg(REG_EDGE_THRESHOLD, $urandom_range(2, 256));
        else if (r < 90) write_reg(REG_EDGE_THRESHOLD, $urandom_range(256, 8192));
        else write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, THRESH_MAX));
      end
      calm   = ($urandom_range(0, 4) == 0);
      w      = live_width();
      base   = height_t'($urandom());
      wild   = ($urandom_range(0, 99) < 15);
      spread = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 8000);
      r      = $urandom_range(0, 99);
      if (r < 8) begin
        // samples then one drain: frame dropped if the last row is partial
        send_samples($urandom_range(0, 2) * w + $urandom_range(1, w), base, spread, wild);
        push_beat(FUNC_DRAIN, height_t'($urandom()));
      end else if (r < 18 && w >= 2) begin
        // narrow the row while the frame is in flight
        j = $urandom_range(0, w - 1);
        send_samples($urandom_range(0, 2) * w + j, base, spread, wild);
        settle();
        w2 = $urandom_range(1, w - 1);
        write_reg(REG_ROW_WIDTH, w2);
        send_samples((j >= w2) ? 1 : w2 - j, base, spread, wild);
        send_samples($urandom_range(0, 2) * w2, base, spread, wild);
        send_drains(w2, 1'b0);
      end else begin
        if (r > 95) push_beat(FUNC_DRAIN, height_t'($urandom()));
        send_samples($urandom_range(1, 4) * w, base, spread, wild);
        send_drains(w, r >= 18 && r < 30);
      end
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      centre_line[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_height_extremes();
    test_discarded_frames();
    test_width_zero();
    test_sample_during_drain();
    test_narrow_mid_frame();
    test_widest_rows();
    test_random_frames();
    $display("Run covered %0d input beats (%0d dropped mid-drain samples) and %0d checked pixels,",
             n_beats, n_strays, n_checked);
    $display("%0d frames drained to the last pixel, widths 0 to 2047, thresholds 0 to max.",
             n_frames);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/hmeps_pkg.sv
sv/hmeps_div.sv
sv/hmeps_dpath.sv
sv/hmeps_ctrl.sv
sv/heightmap_edge_preserving_smooth_core.sv
verif/tb_heightmap_edge_preserving_smooth_core.sv
